FILE: design/rhsv_pkg.sv
`timescale 1ns / 1ps

package rhsv_pkg;

    // Guard bits above the component width for the hue dividend and divisor (6 * spread < 8 * 2^W)
    localparam int HUE_GUARD = 3;

    // Hue sector of the largest component
    typedef logic [1:0] t_sector;
    localparam t_sector SEC_RED      = 2'd0;  // red largest, green at or above blue
    localparam t_sector SEC_GREEN    = 2'd1;
    localparam t_sector SEC_BLUE     = 2'd2;
    localparam t_sector SEC_RED_WRAP = 2'd3;  // red largest, green below blue

    typedef struct packed {
        logic valid;
        logic gray;      // all components equal
        logic sat_full;  // smallest component is zero, spread equals maximum
    } t_pipe_ctl;

endpackage

FILE: design/rhsv_prep.sv
`timescale 1ns / 1ps

module rhsv_prep #(
    parameter int W = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [W-1:0]                      i_red,
    input  logic [W-1:0]                      i_green,
    input  logic [W-1:0]                      i_blue,
    input  logic [W-1:0]                      i_alpha,
    output rhsv_pkg::t_pipe_ctl               o_ctl,
    output logic [W+rhsv_pkg::HUE_GUARD-1:0]  o_num_h,
    output logic [W+rhsv_pkg::HUE_GUARD-1:0]  o_den_h,
    output logic [W-1:0]                      o_num_s,
    output logic [W-1:0]                      o_den_s,
    output logic [W-1:0]                      o_bright,
    output logic [W-1:0]                      o_alpha
);
    import rhsv_pkg::*;

    localparam int TW = W + HUE_GUARD;

    // stage A: largest, smallest, sector and signed difference
    logic              r_a_valid;
    logic [W-1:0]      r_a_mx, r_a_mn, r_a_alpha;
    logic [W:0]        r_a_diff;
    t_sector           r_a_sec;

    // stage B: spread
    logic              r_b_valid;
    logic [W-1:0]      r_b_d, r_b_mx, r_b_alpha;
    logic              r_b_mn_zero;
    logic [W:0]        r_b_diff;
    t_sector           r_b_sec;

    // stage C: dividends and divisors
    t_pipe_ctl         r_c_ctl;
    logic [TW-1:0]     r_c_num_h, r_c_den_h;
    logic [W-1:0]      r_c_num_s, r_c_den_s, r_c_alpha;

    logic              red_max, green_max;
    logic [W-1:0]      n_a_mx, n_a_mn, dif_x, dif_y;
    t_sector           n_a_sec;
    logic [TW-1:0]     d_ext, d2, d4, d6, sec_off, diff_ext, n_c_num_h;

    always_comb begin
        red_max   = (i_red >= i_green) && (i_red >= i_blue);
        green_max = !red_max && (i_green >= i_blue);
        if (red_max) begin
            n_a_mx  = i_red;
            n_a_sec = (i_green < i_blue) ? SEC_RED_WRAP : SEC_RED;
            dif_x   = i_green;
            dif_y   = i_blue;
        end else if (green_max) begin
            n_a_mx  = i_green;
            n_a_sec = SEC_GREEN;
            dif_x   = i_blue;
            dif_y   = i_red;
        end else begin
            n_a_mx  = i_blue;
            n_a_sec = SEC_BLUE;
            dif_x   = i_red;
            dif_y   = i_green;
        end
        n_a_mn = i_red;
        if (i_green < n_a_mn) n_a_mn = i_green;
        if (i_blue < n_a_mn) n_a_mn = i_blue;
    end

    always_comb begin
        d_ext = TW'(r_b_d);
        d2    = d_ext << 1;
        d4    = d_ext << 2;
        d6    = d4 + d2;
        case (r_b_sec)
            SEC_RED:      sec_off = '0;
            SEC_GREEN:    sec_off = d2;
            SEC_BLUE:     sec_off = d4;
            SEC_RED_WRAP: sec_off = d6;
            default:      sec_off = '0;
        endcase
        diff_ext  = {{(TW-W-1){r_b_diff[W]}}, r_b_diff};
        // sum lands in [0, 6 * spread) so the wrap of the two's complement add is exact
        n_c_num_h = sec_off + diff_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_ctl   <= '0;
        end else if (i_en) begin
            r_a_valid        <= i_valid;
            r_b_valid        <= r_a_valid;
            r_c_ctl.valid    <= r_b_valid;
            r_c_ctl.gray     <= (r_b_d == '0);
            r_c_ctl.sat_full <= r_b_mn_zero && (r_b_d != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mx      <= n_a_mx;
            r_a_mn      <= n_a_mn;
            r_a_sec     <= n_a_sec;
            r_a_diff    <= {1'b0, dif_x} - {1'b0, dif_y};
            r_a_alpha   <= i_alpha;

            r_b_d       <= r_a_mx - r_a_mn;
            r_b_mx      <= r_a_mx;
            r_b_mn_zero <= (r_a_mn == '0);
            r_b_diff    <= r_a_diff;
            r_b_sec     <= r_a_sec;
            r_b_alpha   <= r_a_alpha;

            r_c_num_h   <= n_c_num_h;
            r_c_den_h   <= d6;
            r_c_num_s   <= r_b_d;
            r_c_den_s   <= r_b_mx;
            r_c_alpha   <= r_b_alpha;
        end
    end

    assign o_ctl    = r_c_ctl;
    assign o_num_h  = r_c_num_h;
    assign o_den_h  = r_c_den_h;
    assign o_num_s  = r_c_num_s;
    assign o_den_s  = r_c_den_s;
    assign o_bright = r_c_den_s;
    assign o_alpha  = r_c_alpha;

endmodule

FILE: design/rhsv_div_step.sv
`timescale 1ns / 1ps

module rhsv_div_step #(
    parameter int W = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  rhsv_pkg::t_pipe_ctl               i_ctl,
    input  logic [W+rhsv_pkg::HUE_GUARD-1:0]  i_rem_h,
    input  logic [W+rhsv_pkg::HUE_GUARD-1:0]  i_den_h,
    input  logic [W-1:0]                      i_q_h,
    input  logic [W-1:0]                      i_rem_s,
    input  logic [W-1:0]                      i_den_s,
    input  logic [W-1:0]                      i_q_s,
    input  logic [W-1:0]                      i_bright,
    input  logic [W-1:0]                      i_alpha,
    output rhsv_pkg::t_pipe_ctl               o_ctl,
    output logic [W+rhsv_pkg::HUE_GUARD-1:0]  o_rem_h,
    output logic [W+rhsv_pkg::HUE_GUARD-1:0]  o_den_h,
    output logic [W-1:0]                      o_q_h,
    output logic [W-1:0]                      o_rem_s,
    output logic [W-1:0]                      o_den_s,
    output logic [W-1:0]                      o_q_s,
    output logic [W-1:0]                      o_bright,
    output logic [W-1:0]                      o_alpha
);
    import rhsv_pkg::*;

    localparam int TW = W + HUE_GUARD;

    t_pipe_ctl      r_ctl;
    logic [TW-1:0]  r_rem_h, r_den_h;
    logic [W-1:0]   r_q_h, r_rem_s, r_den_s, r_q_s, r_bright, r_alpha;

    logic [TW:0]    sh_h, sub_h;
    logic [W:0]     sh_s, sub_s;
    logic           ge_h, ge_s;
    logic [TW-1:0]  n_rem_h;
    logic [W-1:0]   n_rem_s;

    // one restoring step of each divider: shift, trial subtract, keep or restore
    always_comb begin
        sh_h    = {i_rem_h, 1'b0};
        sub_h   = sh_h - {1'b0, i_den_h};
        ge_h    = (sh_h >= {1'b0, i_den_h});
        n_rem_h = ge_h ? sub_h[TW-1:0] : sh_h[TW-1:0];

        sh_s    = {i_rem_s, 1'b0};
        sub_s   = sh_s - {1'b0, i_den_s};
        ge_s    = (sh_s >= {1'b0, i_den_s});
        n_rem_s = ge_s ? sub_s[W-1:0] : sh_s[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_h  <= n_rem_h;
            r_den_h  <= i_den_h;
            r_q_h    <= {i_q_h[W-2:0], ge_h};
            r_rem_s  <= n_rem_s;
            r_den_s  <= i_den_s;
            r_q_s    <= {i_q_s[W-2:0], ge_s};
            r_bright <= i_bright;
            r_alpha  <= i_alpha;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_rem_h  = r_rem_h;
    assign o_den_h  = r_den_h;
    assign o_q_h    = r_q_h;
    assign o_rem_s  = r_rem_s;
    assign o_den_s  = r_den_s;
    assign o_q_s    = r_q_s;
    assign o_bright = r_bright;
    assign o_alpha  = r_alpha;

endmodule

FILE: design/rgb_to_hsv_pixel.sv
`timescale 1ns / 1ps
// Pipeline: three preparation stages, one divider stage per quotient bit, one output register.
// Throughput: one pixel per cycle unless the output stalls; both dividers retire one quotient bit per stage.
// Reset (synchronous, active low) clears every stage's valid flag; data registers are not reset.
module rgb_to_hsv_pixel #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // red, green, blue, alpha_in; zero padding to whole bytes
    input  logic [((4*COMPONENT_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                      o_m_axis_tvalid,
    input  logic                                      i_m_axis_tready,
    // hue, saturation, brightness, alpha_out; zero padding to whole bytes
    output logic [((4*COMPONENT_BITS+7)/8)*8-1:0]     o_m_axis_tdata
);
    import rhsv_pkg::*;

    localparam int W       = COMPONENT_BITS;
    localparam int TW      = W + HUE_GUARD;
    localparam int TDATA_W = ((4*W+7)/8)*8;

    t_pipe_ctl      w_ctl    [0:W];
    logic [TW-1:0]  w_rem_h  [0:W];
    logic [TW-1:0]  w_den_h  [0:W];
    logic [W-1:0]   w_q_h    [0:W];
    logic [W-1:0]   w_rem_s  [0:W];
    logic [W-1:0]   w_den_s  [0:W];
    logic [W-1:0]   w_q_s    [0:W];
    logic [W-1:0]   w_bright [0:W];
    logic [W-1:0]   w_alpha  [0:W];

    logic           r_out_valid;
    logic [W-1:0]   r_hue, r_sat, r_bright, r_alpha;
    logic           out_load, pipe_en;
    logic [W-1:0]   n_hue, n_sat;

    // the pipe may still advance into an empty last stage while the output beat waits
    assign out_load        = !r_out_valid || i_m_axis_tready;
    assign pipe_en         = out_load || !w_ctl[W].valid;
    assign o_s_axis_tready = pipe_en;

    rhsv_prep #(.W(W)) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (i_s_axis_tvalid),
        .i_red    (i_s_axis_tdata[W-1:0]),
        .i_green  (i_s_axis_tdata[2*W-1:W]),
        .i_blue   (i_s_axis_tdata[3*W-1:2*W]),
        .i_alpha  (i_s_axis_tdata[4*W-1:3*W]),
        .o_ctl    (w_ctl[0]),
        .o_num_h  (w_rem_h[0]),
        .o_den_h  (w_den_h[0]),
        .o_num_s  (w_rem_s[0]),
        .o_den_s  (w_den_s[0]),
        .o_bright (w_bright[0]),
        .o_alpha  (w_alpha[0])
    );

    assign w_q_h[0] = '0;
    assign w_q_s[0] = '0;

    for (genvar k = 0; k < W; k++) begin : g_div
        rhsv_div_step #(.W(W)) u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (pipe_en),
            .i_ctl    (w_ctl[k]),
            .i_rem_h  (w_rem_h[k]),
            .i_den_h  (w_den_h[k]),
            .i_q_h    (w_q_h[k]),
            .i_rem_s  (w_rem_s[k]),
            .i_den_s  (w_den_s[k]),
            .i_q_s    (w_q_s[k]),
            .i_bright (w_bright[k]),
            .i_alpha  (w_alpha[k]),
            .o_ctl    (w_ctl[k+1]),
            .o_rem_h  (w_rem_h[k+1]),
            .o_den_h  (w_den_h[k+1]),
            .o_q_h    (w_q_h[k+1]),
            .o_rem_s  (w_rem_s[k+1]),
            .o_den_s  (w_den_s[k+1]),
            .o_q_s    (w_q_s[k+1]),
            .o_bright (w_bright[k+1]),
            .o_alpha  (w_alpha[k+1])
        );
    end

    // gray pixels force hue and saturation to zero; a zero minimum clamps saturation
    always_comb begin
        n_hue = w_ctl[W].gray ? '0 : w_q_h[W];
        if (w_ctl[W].gray) begin
            n_sat = '0;
        end else if (w_ctl[W].sat_full) begin
            n_sat = '1;
        end else begin
            n_sat = w_q_s[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= w_ctl[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= w_bright[W];
            r_alpha  <= w_alpha[W];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'({r_alpha, r_bright, r_sat, r_hue});

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rhsv_pkg::*;

    localparam int CB = 16;
    localparam int DW = ((4 * CB + 7) / 8) * 8;
    localparam logic [CB-1:0] COMP_MAX = {CB{1'b1}};

    // Declared high field first, so red lands in the lowest bits of tdata
    typedef struct packed {
        logic [CB-1:0] alpha;
        logic [CB-1:0] blue;
        logic [CB-1:0] green;
        logic [CB-1:0] red;
    } t_rgba;

    typedef struct packed {
        logic [CB-1:0] alpha_out;
        logic [CB-1:0] brightness;
        logic [CB-1:0] saturation;
        logic [CB-1:0] hue;
    } t_hsv;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_axis_tvalid = 1'b0;
    logic          o_s_axis_tready;
    logic [DW-1:0] i_s_axis_tdata = '0;  // red, green, blue, alpha_in
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready = 1'b0;
    logic [DW-1:0] o_m_axis_tdata;       // hue, saturation, brightness, alpha_out

    t_rgba pixel_q[$];
    t_hsv  hsv_expect_q[$];

    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    int   n_fail = 0;
    int   n_pixels = 0;
    int   n_checked = 0;
    int   n_gray = 0;
    int   n_full_sat = 0;

    rgb_to_hsv_pixel #(
        .COMPONENT_BITS (CB)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_hsv hsv_of(t_rgba px);
        t_hsv              res;
        t_sector           sec;
        longint unsigned   r, g, b, mx, mn, spread, turn;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        spread = mx - mn;
        res.brightness = mx[CB-1:0];
        res.alpha_out  = px.alpha;
        if (spread == 0) begin
            res.hue        = '0;
            res.saturation = '0;
        end else begin
            // Red beats green, green beats blue on a tie
            if (mx == r) begin
                sec = (g < b) ? SEC_RED_WRAP : SEC_RED;
            end else if (mx == g) begin
                sec = SEC_GREEN;
            end else begin
                sec = SEC_BLUE;
            end
            case (sec)
                SEC_RED:      turn = g - b;
                SEC_RED_WRAP: turn = 6 * spread - (b - g);
                SEC_GREEN:    turn = 2 * spread + b - r;
                default:      turn = 4 * spread + r - g;
            endcase
            res.hue = CB'((turn << CB) / (6 * spread));
            // Exact 1.0 does not fit, clamp to all ones
            if (spread >= mx) res.saturation = COMP_MAX;
            else              res.saturation = CB'((spread << CB) / mx);
        end
        return res;
    endfunction

    task automatic push_pixel(input logic [CB-1:0] r, g, b, a);
        t_rgba px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        px.alpha = a;
        pixel_q.push_back(px);
    endtask

    function automatic logic [CB-1:0] rand_comp();
        return CB'($urandom);
    endfunction

    // Sender and receiver, both driven on the falling edge
    always @(negedge i_clk) begin
        int unsigned in_gap;
        int unsigned out_wait;
        bit          in_burst;
        bit          out_burst;
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || in_fire) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    i_s_axis_tdata  <= pixel_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
                    in_gap = in_burst ? 0 : $urandom_range(0, 3);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            if (out_fire) begin
                if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
                out_wait = out_burst ? 0 : $urandom_range(0, 3);
            end
            if (out_wait > 0) begin
                out_wait--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Predict on every input beat, check on every output beat
    always @(posedge i_clk) begin
        t_hsv got;
        t_hsv want;
        in_fire  <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        out_fire <= i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            hsv_expect_q.push_back(hsv_of(t_rgba'(i_s_axis_tdata)));
            n_pixels++;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_hsv'(o_m_axis_tdata);
            if (hsv_expect_q.size() == 0) begin
                $error("unexpected output beat, tdata %h", o_m_axis_tdata);
                n_fail++;
            end else begin
                want = hsv_expect_q.pop_front();
                n_checked++;
                if (want.saturation == '0) n_gray++;
                if (want.saturation == COMP_MAX) n_full_sat++;
                if (got.hue !== want.hue) begin
                    $error("hue: expected %h, got %h", want.hue, got.hue);
                    n_fail++;
                end
                if (got.saturation !== want.saturation) begin
                    $error("saturation: expected %h, got %h", want.saturation, got.saturation);
                    n_fail++;
                end
                if (got.brightness !== want.brightness) begin
                    $error("brightness: expected %h, got %h", want.brightness, got.brightness);
                    n_fail++;
                end
                if (got.alpha_out !== want.alpha_out) begin
                    $error("alpha_out: expected %h, got %h", want.alpha_out, got.alpha_out);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        logic [CB-1:0] base;
        logic [CB-1:0] c0, c1, c2;
        int            kind;

        // Extremes, gray, full saturation
        push_pixel('0, '0, '0, '0);
        push_pixel(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
        push_pixel(16'h8000, 16'h8000, 16'h8000, 16'h1234);
        push_pixel(COMP_MAX, '0, '0, '0);
        push_pixel('0, COMP_MAX, '0, COMP_MAX);
        push_pixel('0, '0, COMP_MAX, 16'h5555);
        push_pixel(16'd1, '0, '0, 16'hAAAA);
        // Each sector, both signs of the difference
        push_pixel(16'd50000, 16'd30000, 16'd10000, 16'h0001);
        push_pixel(16'd50000, 16'd10000, 16'd30000, 16'h0002);
        push_pixel(16'd30000, 16'd50000, 16'd40000, 16'h0003);
        push_pixel(16'd40000, 16'd50000, 16'd30000, 16'h0004);
        push_pixel(16'd40000, 16'd30000, 16'd50000, 16'h0005);
        push_pixel(16'd30000, 16'd40000, 16'd50000, 16'h0006);
        // Ties for the maximum
        push_pixel(16'd60000, 16'd60000, 16'd1000, 16'h0007);
        push_pixel(16'd60000, 16'd1000, 16'd60000, 16'h0008);
        push_pixel(16'd1000, 16'd60000, 16'd60000, 16'h0009);
        // Smallest spreads and near-zero hue
        push_pixel(COMP_MAX, COMP_MAX - 1, COMP_MAX - 1, 16'hFFFE);
        push_pixel(16'd2, 16'd1, 16'd2, 16'h7FFF);
        push_pixel(COMP_MAX, 16'd0, 16'd1, 16'h8000);
        push_pixel(COMP_MAX, 16'd1, 16'd0, 16'h0F0F);
        push_pixel(16'd1, 16'd1, 16'd0, 16'hF0F0);

        for (int i = 0; i < 1950; i++) begin
            kind = $urandom_range(0, 9);
            base = rand_comp();
            c0 = rand_comp();
            c1 = rand_comp();
            c2 = rand_comp();
            case (kind)
                3: begin
                    c0 = base;
                    c1 = base;
                    c2 = base;
                end
                4: begin
                    if (base > COMP_MAX - 3) base = COMP_MAX - 3;
                    c0 = base + CB'($urandom_range(0, 3));
                    c1 = base + CB'($urandom_range(0, 3));
                    c2 = base + CB'($urandom_range(0, 3));
                end
                5: begin
                    case ($urandom_range(0, 2))
                        0:       c0 = '0;
                        1:       c1 = '0;
                        default: c2 = '0;
                    endcase
                end
                6: begin
                    c0 = base;
                    if ($urandom_range(0, 1)) c1 = base;
                    else                      c2 = base;
                end
                7: begin
                    c0 = CB'($urandom_range(0, 15));
                    c1 = CB'($urandom_range(0, 15));
                    c2 = CB'($urandom_range(0, 15));
                end
                8: begin
                    c0 = COMP_MAX - CB'($urandom_range(0, 15));
                    c1 = COMP_MAX - CB'($urandom_range(0, 15));
                    c2 = COMP_MAX - CB'($urandom_range(0, 15));
                end
                9: begin
                    case ($urandom_range(0, 2))
                        0:       c0 = COMP_MAX;
                        1:       c1 = COMP_MAX;
                        default: c2 = COMP_MAX;
                    endcase
                end
                default: ;
            endcase
            // Rotate so every pattern reaches every colour
            case ($urandom_range(0, 2))
                0:       push_pixel(c0, c1, c2, rand_comp());
                1:       push_pixel(c1, c2, c0, rand_comp());
                default: push_pixel(c2, c0, c1, rand_comp());
            endcase
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (pixel_q.size() != 0 || i_s_axis_tvalid || hsv_expect_q.size() != 0);
        // Let any stray beat show up before judging
        repeat (40) @(posedge i_clk);

        $display("converted %0d pixels, checked %0d results", n_pixels, n_checked);
        $display("including %0d gray and %0d fully saturated pixels", n_gray, n_full_sat);
        if (n_fail == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout with %0d results outstanding", hsv_expect_q.size());
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
